// ===== rtl/sll_pkg.sv =====
// Shared types, character codes and keyword table for the stack language lexer.
package sll_pkg;

    // Keyword compare window: no keyword is longer than this
    localparam int KW_CHARS = 8;
    localparam int KW_LEN_W = $clog2(KW_CHARS + 1);
    localparam int KW_NUM   = 33;

    typedef logic [5:0] t_class;
    typedef logic [KW_CHARS-1:0][7:0] t_head;

    // Token classes with a meaning of their own
    localparam t_class CLS_UNKNOWN = 6'd0;
    localparam t_class CLS_INTEGER = 6'd1;
    localparam t_class CLS_STRING  = 6'd2;

    // Result kinds
    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_TOKEN = 1'b1;

    // Character codes
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_BSLASH     = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_N    = 8'h6E;

    // One result item
    typedef struct packed {
        logic               kind;
        t_class             token_class;
        logic signed [31:0] int_value;
        logic [7:0]         out_char;
        logic               too_long;
    } t_result;

    // Keyword spellings (last character in the low byte), lengths and classes
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_NUM] = '{
        "sdup", "sswap", "sdrop", "s.", "s.s",
        "concat", "len", "dup", "drop", "swap", ".", ".s",
        "+", "-", "*", "/", "%", "=", "!=", ">", ">=", "<", "<=",
        "itos", "itoc", "ctoi", "headtail", "if", "else", "endif",
        "while", "endwhile", "define"
    };

    localparam logic [KW_LEN_W-1:0] KW_LEN [KW_NUM] = '{
        4'd4, 4'd5, 4'd5, 4'd2, 4'd3,
        4'd6, 4'd3, 4'd3, 4'd4, 4'd4, 4'd1, 4'd2,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd2,
        4'd4, 4'd4, 4'd4, 4'd8, 4'd2, 4'd4, 4'd5,
        4'd5, 4'd8, 4'd6
    };

    localparam t_class KW_CLS [KW_NUM] = '{
        6'd22, 6'd23, 6'd24, 6'd25, 6'd26,
        6'd27, 6'd29, 6'd4, 6'd6, 6'd5, 6'd7, 6'd8,
        6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19,
        6'd20, 6'd21, 6'd30, 6'd28, 6'd31, 6'd32, 6'd33,
        6'd34, 6'd35, 6'd3
    };

endpackage

// ===== rtl/sll_kw_match.sv =====
// Parallel keyword comparator over the first bytes of a token.
module sll_kw_match (
    input  sll_pkg::t_head                   i_head,
    input  logic [sll_pkg::KW_LEN_W-1:0]     i_len,
    output sll_pkg::t_class                  o_class
);
    import sll_pkg::*;

    logic [KW_NUM-1:0] w_hit;

    // One comparator per keyword; spelling is reordered so the first char sits in byte 0
    for (genvar k = 0; k < KW_NUM; k++) begin : g_kw
        t_head w_ref;
        for (genvar b = 0; b < KW_CHARS; b++) begin : g_byte
            if (b < KW_LEN[k]) begin : g_used
                assign w_ref[b] = KW_TEXT[k][8*(KW_LEN[k]-1-b) +: 8];
            end else begin : g_pad
                assign w_ref[b] = 8'h00;
            end
        end
        assign w_hit[k] = (i_head == w_ref) && (i_len == KW_LEN[k]);
    end

    // Spellings are distinct, so at most one hit
    always_comb begin
        o_class = CLS_UNKNOWN;
        for (int k = 0; k < KW_NUM; k++) begin
            o_class = o_class | (w_hit[k] ? KW_CLS[k] : CLS_UNKNOWN);
        end
    end

endmodule

// ===== rtl/sll_lexer.sv =====
// Token state and per-byte step logic of the lexer.
module sll_lexer #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output logic             o_valid,
    output sll_pkg::t_result o_result
);
    import sll_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

    t_head              r_head,       n_head;
    logic [LEN_W-1:0]   r_len,        n_len;
    logic [31:0]        r_acc,        n_acc;
    logic               r_digits,     n_digits;
    logic               r_neg,        n_neg;
    logic               r_in_string,  n_in_string;
    logic               r_escape,     n_escape;
    logic               r_at_boundary, n_at_boundary;
    logic               r_first,      n_first;
    logic               r_overflow,   n_overflow;

    logic                w_space;
    logic                w_digit;
    logic                w_pos_zero;
    logic                w_len_full;
    logic                w_is_int;
    logic [KW_LEN_W-1:0] w_len_short;
    t_class              w_kw_class;
    t_result             w_token;
    logic                w_emit_char;
    logic [7:0]          w_char;

    // Byte classes
    assign w_space    = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
    assign w_digit    = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_pos_zero = (r_len == '0);
    assign w_len_full = (r_len >= LEN_W'(MAX_TOKEN_LEN));

    // Classification of the pending token
    assign w_is_int    = r_digits && (r_len != '0) && !(r_neg && (r_len == LEN_W'(1)));
    assign w_len_short = (r_len <= LEN_W'(KW_CHARS)) ? r_len[KW_LEN_W-1:0] : '0;

    sll_kw_match u_kw_match (
        .i_head  (r_head),
        .i_len   (w_len_short),
        .o_class (w_kw_class)
    );

    always_comb begin
        w_token.kind     = KIND_TOKEN;
        w_token.too_long = r_overflow;
        w_token.out_char = 8'h00;
        if (w_is_int) begin
            w_token.token_class = CLS_INTEGER;
            w_token.int_value   = r_neg ? (32'sd0 - $signed(r_acc)) : $signed(r_acc);
        end else begin
            w_token.token_class = r_in_string ? CLS_STRING : w_kw_class;
            w_token.int_value   = 32'sd0;
        end
    end

    // Next state and result of one byte
    always_comb begin
        n_head        = r_head;
        n_len         = r_len;
        n_acc         = r_acc;
        n_digits      = r_digits;
        n_neg         = r_neg;
        n_in_string   = r_in_string;
        n_escape      = r_escape;
        n_at_boundary = r_at_boundary;
        n_first       = r_first;
        n_overflow    = r_overflow;
        o_valid       = 1'b0;
        w_emit_char   = 1'b0;
        w_char        = i_byte;

        if (i_step) begin
            if (i_last) begin
                // end of input: flush and return to the reset state
                o_valid       = !r_at_boundary;
                n_head        = '0;
                n_len         = '0;
                n_acc         = '0;
                n_digits      = 1'b1;
                n_neg         = 1'b0;
                n_in_string   = 1'b0;
                n_escape      = 1'b0;
                n_overflow    = 1'b0;
                n_at_boundary = 1'b1;
                n_first       = 1'b1;
            end else if (w_space) begin
                // leading whitespace gives an empty unknown token (state is already clear)
                o_valid       = r_first || !r_at_boundary;
                n_head        = '0;
                n_len         = '0;
                n_acc         = '0;
                n_digits      = 1'b1;
                n_neg         = 1'b0;
                n_in_string   = 1'b0;
                n_escape      = 1'b0;
                n_overflow    = 1'b0;
                n_at_boundary = 1'b1;
                n_first       = 1'b0;
            end else begin
                n_first       = 1'b0;
                n_at_boundary = 1'b0;
                if (w_len_full) begin
                    n_overflow = 1'b1;
                end else begin
                    n_len = r_len + LEN_W'(1);
                    for (int b = 0; b < KW_CHARS; b++) begin
                        if (r_len == LEN_W'(b)) begin
                            n_head[b] = i_byte;
                        end
                    end
                    // integer form tracking
                    if (w_pos_zero && (i_byte == CH_MINUS)) begin
                        n_neg = 1'b1;
                    end else if (w_digit) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + {28'd0, i_byte[3:0]};
                    end else begin
                        n_digits = 1'b0;
                    end
                    // string decoding
                    if (w_pos_zero) begin
                        n_in_string = (i_byte == CH_QUOTE);
                    end else if (r_in_string) begin
                        if (r_escape) begin
                            n_escape    = 1'b0;
                            w_emit_char = 1'b1;
                            w_char      = (i_byte == CH_LOWER_N) ? CH_NEWLINE : i_byte;
                        end else if (i_byte == CH_UNDERSCORE) begin
                            w_emit_char = 1'b1;
                            w_char      = CH_SPACE;
                        end else if (i_byte == CH_BSLASH) begin
                            n_escape = 1'b1;
                        end else begin
                            w_emit_char = 1'b1;
                        end
                    end
                end
            end
        end

        if (w_emit_char) begin
            o_valid              = 1'b1;
            o_result.kind        = KIND_CHAR;
            o_result.token_class = CLS_STRING;
            o_result.int_value   = 32'sd0;
            o_result.out_char    = w_char;
            o_result.too_long    = 1'b0;
        end else begin
            o_result = w_token;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_len         <= '0;
            r_acc         <= '0;
            r_digits      <= 1'b1;
            r_neg         <= 1'b0;
            r_in_string   <= 1'b0;
            r_escape      <= 1'b0;
            r_at_boundary <= 1'b1;
            r_first       <= 1'b1;
            r_overflow    <= 1'b0;
        end else begin
            r_head        <= n_head;
            r_len         <= n_len;
            r_acc         <= n_acc;
            r_digits      <= n_digits;
            r_neg         <= n_neg;
            r_in_string   <= n_in_string;
            r_escape      <= n_escape;
            r_at_boundary <= n_at_boundary;
            r_first       <= n_first;
            r_overflow    <= n_overflow;
        end
    end

`ifndef SYNTHESIS
    a_escape_in_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_escape |-> r_in_string)
        else $error("escape pending outside a string token");

    a_open_token_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_at_boundary |-> (r_len != '0))
        else $error("open token with no kept bytes");

    a_end_restores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> (r_first && r_at_boundary && (r_len == '0)))
        else $error("end of input did not restore the start state");
`endif

endmodule

// ===== rtl/sll_out_fifo.sv =====
// Two-entry result queue that decouples the lexer step from the output stall.
module sll_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sll_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_ready,
    output sll_pkg::t_result o_data
);
    import sll_pkg::*;

    localparam int DEPTH = 2;

    t_result    r_mem [DEPTH];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;
    logic       w_pop;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && i_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Result storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("result pushed into a full queue");
`endif

endmodule

// ===== rtl/stack_language_lexer_core.sv =====
// Top level of the stack language lexer: input register, lexer step, result queue.
//
// Usage:
//   Slave stream: one source byte per request on tdata; tlast marks end of
//   input (the byte is then ignored) and flushes any pending token.
//   Master stream: at most one result per input byte. tuser is the kind
//   (0 decoded string character, 1 completed token); tdata carries the
//   token class, integer value, decoded character and too-long flag.
//   Throughput: one byte per cycle, sustained, while the receiver takes
//   results. Each accepted byte passes the input register, then the lexer
//   step into the queue, before its result is on the master side.
//   tready on the slave side depends on registers only: it drops when the
//   input register holds a byte and the two-entry result queue is full, so
//   a stalled receiver holds up at most two results plus one byte.
//   Reset (synchronous, active low) empties the pipeline and puts the
//   lexer at start of input, where leading whitespace gives an empty
//   unknown token.
module stack_language_lexer_core #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_in
    input  logic        i_s_axis_tlast,   // end_of_input
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [5:0] token_class, [37:6] int_value,
                                          // [45:38] out_char, [46] too_long, [47] zero
    output logic        o_m_axis_tuser    // kind
);
    import sll_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic       w_accept;
    logic       w_advance;
    logic       w_full;
    logic       w_push;
    t_result    w_step_result;
    t_result    w_out;

    // Input register
    assign o_s_axis_tready = !r_in_valid || !w_full;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_advance       = r_in_valid && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // Lexer step
    sll_lexer #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_valid  (w_push),
        .o_result (w_step_result)
    );

    // Result queue
    sll_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_step_result),
        .o_full  (w_full),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_out)
    );

    // Output packing
    assign o_m_axis_tdata = {1'b0, w_out.too_long, w_out.out_char, w_out.int_value,
                             w_out.token_class};
    assign o_m_axis_tuser = w_out.kind;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for stack_language_lexer_core: byte requests in, tokens and chars checked.
module tb_top;

    localparam int TOK_MAX  = 255;
    localparam int KW_WIN   = 8;
    localparam int KW_COUNT = 33;

    // Character codes
    localparam logic [7:0] C_TAB        = 8'h09;
    localparam logic [7:0] C_NEWLINE    = 8'h0A;
    localparam logic [7:0] C_VTAB       = 8'h0B;
    localparam logic [7:0] C_FORMFEED   = 8'h0C;
    localparam logic [7:0] C_CR         = 8'h0D;
    localparam logic [7:0] C_SPACE      = 8'h20;
    localparam logic [7:0] C_QUOTE      = 8'h27;
    localparam logic [7:0] C_MINUS      = 8'h2D;
    localparam logic [7:0] C_ZERO       = 8'h30;
    localparam logic [7:0] C_NINE       = 8'h39;
    localparam logic [7:0] C_BSLASH     = 8'h5C;
    localparam logic [7:0] C_UNDERSCORE = 8'h5F;
    localparam logic [7:0] C_LOWER_A    = 8'h61;
    localparam logic [7:0] C_LOWER_N    = 8'h6E;
    localparam logic [7:0] C_LOWER_S    = 8'h73;
    localparam logic [7:0] C_NUL        = 8'h00;
    localparam logic [7:0] C_TOP        = 8'hFF;

    // Token classes in their numbering order
    typedef enum logic [5:0] {
        TC_UNKNOWN, TC_INTEGER, TC_STRING, TC_DEFINE, TC_DUP, TC_SWAP, TC_DROP,
        TC_DOT, TC_DOT_S, TC_PLUS, TC_MINUS, TC_STAR, TC_SLASH, TC_PERCENT,
        TC_EQ, TC_NE, TC_GT, TC_GE, TC_LT, TC_LE, TC_ITOS, TC_ITOC,
        TC_SDUP, TC_SSWAP, TC_SDROP, TC_S_DOT, TC_S_DOT_S, TC_CONCAT,
        TC_HEADTAIL, TC_LEN, TC_CTOI, TC_IF, TC_ELSE, TC_ENDIF, TC_WHILE,
        TC_ENDWHILE
    } t_tok_class;

    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_TOKEN = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
    } t_byte_req;

    typedef struct packed {
        logic        kind;
        logic [5:0]  cls;
        logic [31:0] val;
        logic [7:0]  ch;
        logic        too_long;
    } t_lexeme;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        src_tvalid = 1'b0;
    logic [7:0]  src_tdata = 8'd0;
    logic        src_tlast = 1'b0;
    logic        snk_tready = 1'b0;
    logic        dut_s_tready;
    logic        dut_m_tvalid;
    logic [47:0] dut_m_tdata;
    logic        dut_m_tuser;

    t_byte_req   req_q[$];
    t_lexeme     lexeme_q[$];
    int          n_put = 0;
    int          n_acc = 0;
    int          errs = 0;
    int          idle_pct = 0;
    int          kw_cycle = 0;
    int          src_gap = 0;
    int          snk_gap = 0;
    logic        src_fired = 1'b0;

    // Lexer state as predicted
    logic [7:0]  hd [0:KW_WIN-1];
    int          tok_len;
    logic [31:0] acc;
    logic        only_digits;
    logic        neg_sign;
    logic        quoted;
    logic        esc_wait;
    logic        between_tokens;
    logic        fresh_input;
    logic        clipped;

    stack_language_lexer_core #(
        .MAX_TOKEN_LEN (TOK_MAX)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (src_tvalid),
        .o_s_axis_tready (dut_s_tready),
        .i_s_axis_tdata  (src_tdata),    // [7:0] byte_in
        .i_s_axis_tlast  (src_tlast),    // end_of_input
        .o_m_axis_tvalid (dut_m_tvalid),
        .i_m_axis_tready (snk_tready),
        .o_m_axis_tdata  (dut_m_tdata),  // [5:0] class, [37:6] value, [45:38] char,
                                         // [46] too_long, [47] zero
        .o_m_axis_tuser  (dut_m_tuser)   // kind
    );

    function automatic logic is_ws(logic [7:0] c);
        return c == C_SPACE || (c >= C_TAB && c <= C_CR);
    endfunction

    function automatic void clear_token();
        for (int i = 0; i < KW_WIN; i++) hd[i] = 8'd0;
        tok_len = 0;
        acc = 32'd0;
        only_digits = 1'b1;
        neg_sign = 1'b0;
        quoted = 1'b0;
        esc_wait = 1'b0;
        clipped = 1'b0;
    endfunction

    function automatic void restart_input();
        clear_token();
        between_tokens = 1'b1;
        fresh_input = 1'b1;
    endfunction

    // Class of the token held so far
    function automatic logic [5:0] classify();
        logic [63:0] w;
        t_tok_class k;
        if (only_digits && tok_len > (neg_sign ? 1 : 0)) return TC_INTEGER;
        if (tok_len > 0 && hd[0] == C_QUOTE) return TC_STRING;
        // a leading zero byte would hide in the packed compare, and no keyword has one
        if (tok_len == 0 || tok_len > KW_WIN || hd[0] == C_NUL) return TC_UNKNOWN;
        w = '0;
        for (int i = 0; i < tok_len; i++) w = {w[55:0], hd[i]};
        case (w)
            "sdup":     k = TC_SDUP;
            "sswap":    k = TC_SSWAP;
            "sdrop":    k = TC_SDROP;
            "s.":       k = TC_S_DOT;
            "s.s":      k = TC_S_DOT_S;
            "concat":   k = TC_CONCAT;
            "len":      k = TC_LEN;
            "dup":      k = TC_DUP;
            "drop":     k = TC_DROP;
            "swap":     k = TC_SWAP;
            ".":        k = TC_DOT;
            ".s":       k = TC_DOT_S;
            "+":        k = TC_PLUS;
            "-":        k = TC_MINUS;
            "*":        k = TC_STAR;
            "/":        k = TC_SLASH;
            "%":        k = TC_PERCENT;
            "=":        k = TC_EQ;
            "!=":       k = TC_NE;
            ">":        k = TC_GT;
            ">=":       k = TC_GE;
            "<":        k = TC_LT;
            "<=":       k = TC_LE;
            "itos":     k = TC_ITOS;
            "itoc":     k = TC_ITOC;
            "ctoi":     k = TC_CTOI;
            "headtail": k = TC_HEADTAIL;
            "if":       k = TC_IF;
            "else":     k = TC_ELSE;
            "endif":    k = TC_ENDIF;
            "while":    k = TC_WHILE;
            "endwhile": k = TC_ENDWHILE;
            "define":   k = TC_DEFINE;
            default:    k = TC_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic void push_token();
        t_lexeme r;
        r.kind = KIND_TOKEN;
        r.cls = classify();
        r.val = (r.cls == TC_INTEGER) ? (neg_sign ? 32'd0 - acc : acc) : 32'd0;
        r.ch = 8'd0;
        r.too_long = clipped;
        lexeme_q.push_back(r);
    endfunction

    function automatic void push_char(logic [7:0] c);
        t_lexeme r;
        r.kind = KIND_CHAR;
        r.cls = TC_STRING;
        r.val = 32'd0;
        r.ch = c;
        r.too_long = 1'b0;
        lexeme_q.push_back(r);
    endfunction

    // Advance the predicted lexer by one accepted request
    function automatic void lex_byte(logic [7:0] c, logic eoi);
        int pos;
        if (eoi) begin
            if (!between_tokens) push_token();
            restart_input();
            return;
        end
        if (is_ws(c)) begin
            // whitespace first in the input gives an empty unknown token
            if (fresh_input) begin
                clear_token();
                push_token();
            end else if (!between_tokens) begin
                push_token();
            end
            clear_token();
            fresh_input = 1'b0;
            between_tokens = 1'b1;
            return;
        end
        fresh_input = 1'b0;
        between_tokens = 1'b0;
        if (tok_len >= TOK_MAX) begin
            clipped = 1'b1;
            return;
        end
        pos = tok_len;
        tok_len = pos + 1;
        if (pos < KW_WIN) hd[pos] = c;
        if (pos == 0 && c == C_MINUS) begin
            neg_sign = 1'b1;
        end else if (c >= C_ZERO && c <= C_NINE) begin
            acc = acc * 32'd10 + {24'd0, c - C_ZERO};
        end else begin
            only_digits = 1'b0;
        end
        if (pos == 0) begin
            quoted = (c == C_QUOTE);
            return;
        end
        if (!quoted) return;
        // decode string body
        if (esc_wait) begin
            esc_wait = 1'b0;
            push_char(c == C_LOWER_N ? C_NEWLINE : c);
        end else if (c == C_UNDERSCORE) begin
            push_char(C_SPACE);
        end else if (c == C_BSLASH) begin
            esc_wait = 1'b1;
        end else begin
            push_char(c);
        end
    endfunction

    // Request builders
    function automatic void put_byte(logic [7:0] c);
        t_byte_req r;
        r.data = c;
        r.eoi = 1'b0;
        req_q.push_back(r);
        n_put++;
    endfunction

    function automatic void put_eoi();
        t_byte_req r;
        r.data = 8'($urandom_range(0, 255));
        r.eoi = 1'b1;
        req_q.push_back(r);
        n_put++;
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic logic [7:0] rnd_solid();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (is_ws(b)) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] rnd_ws();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? C_SPACE : C_TAB + 8'(r);
    endfunction

    function automatic string kw_word(int k);
        case (k)
            0: return "sdup";    1: return "sswap";   2: return "sdrop";
            3: return "s.";      4: return "s.s";     5: return "concat";
            6: return "len";     7: return "dup";     8: return "drop";
            9: return "swap";    10: return ".";      11: return ".s";
            12: return "+";      13: return "-";      14: return "*";
            15: return "/";      16: return "%";      17: return "=";
            18: return "!=";     19: return ">";      20: return ">=";
            21: return "<";      22: return "<=";     23: return "itos";
            24: return "itoc";   25: return "ctoi";   26: return "headtail";
            27: return "if";     28: return "else";   29: return "endif";
            30: return "while";  31: return "endwhile";
            default: return "define";
        endcase
    endfunction

    // One random token, mostly well formed
    function automatic void put_token();
        int sel;
        int n;
        int mode;
        int idx;
        string w;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            // keywords: all of them in turn first, then at random
            put_text(kw_word(kw_cycle < KW_COUNT ? kw_cycle : $urandom_range(0, KW_COUNT - 1)));
            kw_cycle++;
        end else if (sel < 45) begin
            // integers, some long enough to wrap, some spoiled at the end
            if ($urandom_range(0, 2) == 0) put_byte(C_MINUS);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
            repeat (n) put_byte(C_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 7) == 0) put_byte(rnd_solid());
        end else if (sel < 65) begin
            // strings with escapes and underscores
            put_byte(C_QUOTE);
            n = $urandom_range(0, 8);
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0, 1: put_byte(C_UNDERSCORE);
                    2, 3: put_byte(C_BSLASH);
                    4: put_byte(C_LOWER_N);
                    5: put_byte(C_QUOTE);
                    default: put_byte(rnd_solid());
                endcase
            end
        end else if (sel < 80) begin
            // near misses: truncated, extended, s-prefixed, altered, minus-prefixed
            w = kw_word($urandom_range(0, KW_COUNT - 1));
            mode = $urandom_range(0, 4);
            idx = $urandom_range(0, w.len() - 1);
            if (mode == 2) put_byte(C_LOWER_S);
            if (mode == 4) put_byte(C_MINUS);
            for (int i = 0; i < w.len(); i++) begin
                if (mode == 3 && i == idx) begin
                    put_byte(rnd_solid());
                end else if (!(mode == 0 && i == w.len() - 1 && i > 0)) begin
                    put_byte(w[i]);
                end
            end
            if (mode == 1) put_byte(C_LOWER_A + 8'($urandom_range(0, 25)));
        end else if (sel < 90) begin
            n = $urandom_range(1, 8);
            repeat (n) put_byte(rnd_solid());
        end else begin
            // raw noise, whitespace included
            n = $urandom_range(1, 8);
            repeat (n) put_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // Token separator, now and then an end of input
    function automatic void put_sep();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            put_eoi();
            if ($urandom_range(0, 1) == 1) put_byte(rnd_ws());
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) put_byte(rnd_ws());
            if (r < 12) put_eoi();
        end
    endfunction

    // Token around the length limit
    function automatic void put_long();
        int n;
        n = $urandom_range(252, 262);
        if ($urandom_range(0, 1) == 1) begin
            put_byte(C_QUOTE);
            repeat (n - 1) put_byte(rnd_solid());
        end else begin
            repeat (n) put_byte(C_ZERO + 8'($urandom_range(0, 9)));
        end
        put_byte(rnd_ws());
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errs++;
        end
    endfunction

    // Clock and reset
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Request driver
    always @(negedge i_clk) begin : src_drive
        t_byte_req cur;
        if (i_rst_n && !(src_tvalid && !src_fired)) begin
            if (src_gap > 0) begin
                src_gap--;
                src_tvalid <= 1'b0;
            end else if (req_q.size() == 0) begin
                src_tvalid <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                src_gap = $urandom_range(0, 8);
                src_tvalid <= 1'b0;
            end else begin
                cur = req_q.pop_front();
                src_tdata <= cur.data;
                src_tlast <= cur.eoi;
                src_tvalid <= 1'b1;
            end
        end
    end

    // Result receiver back-pressure
    always @(negedge i_clk) begin : snk_drive
        if (i_rst_n) begin
            if (snk_gap > 0) begin
                snk_gap--;
                snk_tready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                snk_gap = $urandom_range(0, 8);
                snk_tready <= 1'b0;
            end else begin
                snk_tready <= 1'b1;
            end
        end
    end

    // Monitor: check results, then predict from accepted requests
    always @(posedge i_clk) begin : monitor
        t_lexeme want;
        src_fired = 1'b0;
        if (i_rst_n) begin
            if (dut_m_tvalid && snk_tready) begin
                if (lexeme_q.size() == 0) begin
                    $error("result with nothing pending: kind %0d class %0d data 0x%0h",
                           dut_m_tuser, dut_m_tdata[5:0], dut_m_tdata);
                    errs++;
                end else begin
                    want = lexeme_q.pop_front();
                    check_field("kind", want.kind, dut_m_tuser);
                    check_field("token_class", want.cls, dut_m_tdata[5:0]);
                    check_field("int_value", want.val, dut_m_tdata[37:6]);
                    check_field("out_char", want.ch, dut_m_tdata[45:38]);
                    check_field("too_long", want.too_long, dut_m_tdata[46]);
                    check_field("tdata pad", 32'd0, dut_m_tdata[47]);
                end
            end
            if (src_tvalid && dut_s_tready) begin
                lex_byte(src_tdata, src_tlast);
                n_acc++;
                src_fired = 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        int limit;
        int k;
        restart_input();
        idle_pct = 20;

        // directed: leading whitespace, lone minus, string escapes with a
        // trailing lone backslash flushed by end of input, whitespace first
        // after an end, negative zero, extreme bytes, an s-form, end at boundary
        put_byte(C_SPACE);
        put_text("-");
        put_byte(C_TAB);
        put_text("'a_");
        put_byte(C_BSLASH);
        put_byte(C_LOWER_N);
        put_byte(C_BSLASH);
        put_eoi();
        put_byte(C_VTAB);
        put_text("-0");
        put_byte(C_CR);
        put_byte(C_TOP);
        put_byte(C_NUL);
        put_byte(C_FORMFEED);
        put_text("sswap");
        put_byte(C_NEWLINE);
        put_eoi();

        // hold the sender until every pending result is back
        while (n_acc != n_put || lexeme_q.size() != 0) @(negedge i_clk);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0, 4: idle_pct = 30;
                1, 3: idle_pct = 12;
                default: idle_pct = 0;
            endcase
            limit = n_put + ((ph == 5) ? 120 : 90);
            if (ph == 1 || ph == 3) put_long();
            while (n_put < limit) begin
                put_token();
                put_sep();
            end
            while (req_q.size() != 0) @(negedge i_clk);
        end
        put_eoi();

        while (n_acc != n_put) @(negedge i_clk);
        k = 0;
        while (lexeme_q.size() != 0 && k < 20000) begin
            @(negedge i_clk);
            k++;
        end
        repeat (16) @(negedge i_clk);
        if (lexeme_q.size() != 0) begin
            $error("%0d expected results never arrived", lexeme_q.size());
            errs++;
        end
        if (errs == 0) begin
            $display("stack_language_lexer_core verification clean");
        end else begin
            $display("stack_language_lexer_core verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("stack_language_lexer_core verification failed");
        $finish;
    end

endmodule
